@@ hdl/ppd_pkg.sv @@
// Shared types and constants for the plug presence debouncer.
`default_nettype none

package ppd_pkg;

    // Event codes carried on event_res
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } event_t;

    // Configuration register indexes
    localparam logic [2:0] REG_USE_ADC        = 3'd0;
    localparam logic [2:0] REG_ADC_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_PULL_UP_FITTED = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE_COUNT = 3'd3;
    localparam logic [2:0] REG_SAMPLING_MODE  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 8;

    // Register reset values and the hold counter's saturation value
    localparam int          THRESHOLD_RESET = 512;
    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd3;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;

endpackage

`default_nettype wire

@@ hdl/plug_presence_debouncer_unit.sv @@
// Plug presence debouncer: top level with config registers, tick logic and result register.
//
// Usage
//   Input channel (in_valid/in_ready) carries one sample word per tick:
//   pin_level, adc_value and sample_ok. Output channel (out_valid/out_ready)
//   returns one result word per sample: event_res, settling, fast_scan, present.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), taken
//   at any edge with cfg_we high; indexes beyond the list are ignored. Write
//   it only while no sample is in flight.
// Processing and throughput
//   A sample is processed by one pass of combinational logic as it is taken;
//   its result is written to the output register as it is taken. One
//   sample per cycle is sustained: the result register drains and refills in
//   the same cycle when out_ready is high.
// Reset
//   rst_n (asynchronous, active low) clears the detector state (absent,
//   offline, not armed, count 0), loads register defaults and empties the
//   output register.
// Stall
//   While a result waits with out_ready low, in_ready is low and the word
//   and state hold; nothing is lost or repeated.
`default_nettype none

module plug_presence_debouncer_unit #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port, as wide as the widest register
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [((ADC_BITS > ppd_pkg::COUNT_W) ? ADC_BITS : ppd_pkg::COUNT_W)-1:0]
                                        cfg_data,
    // sample channel
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic                   pin_level,
    input  wire logic [ADC_BITS-1:0]    adc_value,
    input  wire logic                   sample_ok,
    // result channel
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [1:0]             event_res,
    output      logic                   settling,
    output      logic                   fast_scan,
    output      logic                   present
);

    // Configuration registers
    logic                      use_adc_reg;
    logic [ADC_BITS-1:0]       adc_threshold_reg;
    logic                      pull_up_fitted_reg;
    logic [7:0]                debounce_count_reg;
    logic                      sampling_mode_reg;

    // Detector state
    logic                      level_seen_reg, level_seen_next;
    logic [7:0]                hold_count_reg, hold_count_next;
    logic                      changing_reg, changing_next;
    logic                      online_flag_reg, online_flag_next;
    logic                      awake_reg, awake_next;

    // Result register
    logic                      out_valid_reg;
    ppd_pkg::event_t           event_reg, event_next;
    logic                      settling_reg, settling_next;
    logic                      fast_scan_reg, fast_scan_next;
    logic                      present_reg;

    logic                      take;
    logic                      sensed;
    logic                      cur;
    logic [7:0]                count_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign settling  = settling_reg;
    assign fast_scan = fast_scan_reg;
    assign present   = present_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_adc_reg        <= 1'b0;
            adc_threshold_reg  <= ADC_BITS'(ppd_pkg::THRESHOLD_RESET);
            pull_up_fitted_reg <= 1'b1;
            debounce_count_reg <= ppd_pkg::DEBOUNCE_RESET;
            sampling_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppd_pkg::REG_USE_ADC:        use_adc_reg        <= cfg_data[0];
                ppd_pkg::REG_ADC_THRESHOLD:  adc_threshold_reg  <= cfg_data[ADC_BITS-1:0];
                ppd_pkg::REG_PULL_UP_FITTED: pull_up_fitted_reg <= cfg_data[0];
                ppd_pkg::REG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_data[7:0];
                ppd_pkg::REG_SAMPLING_MODE:  sampling_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Raw presence: pin low, or reading at or below threshold
    assign sensed = use_adc_reg ? (adc_value <= adc_threshold_reg) : !pin_level;

    // Saturating increment of the hold counter
    assign count_inc = (hold_count_reg == ppd_pkg::COUNT_MAX) ? ppd_pkg::COUNT_MAX
                                                              : hold_count_reg + 8'd1;

    always_comb
    begin
        level_seen_next  = level_seen_reg;
        hold_count_next  = hold_count_reg;
        changing_next    = changing_reg;
        online_flag_next = online_flag_reg;
        awake_next       = awake_reg;
        event_next       = ppd_pkg::EV_NONE;
        settling_next    = changing_reg;
        fast_scan_next   = 1'b1;
        cur              = sensed;

        if (sampling_mode_reg)
        begin
            // Multiplexed: count disagreeing samples, flip on reaching the count
            if (use_adc_reg && !sample_ok)
            begin
                cur = level_seen_reg;
            end
            if (cur == level_seen_reg)
            begin
                hold_count_next = '0;
            end
            else
            begin
                hold_count_next = count_inc;
                if (count_inc >= debounce_count_reg)
                begin
                    hold_count_next  = '0;
                    level_seen_next  = cur;
                    online_flag_next = cur;
                    event_next       = cur ? ppd_pkg::EV_ON : ppd_pkg::EV_OFF;
                end
            end
            settling_next = (hold_count_next != '0);
        end
        else if (!awake_reg)
        begin
            // Wake tick: arm only
            awake_next = 1'b1;
        end
        else
        begin
            cur = sensed ^ !pull_up_fitted_reg;
            if (cur != level_seen_reg)
            begin
                level_seen_next = cur;
                hold_count_next = '0;
                changing_next   = 1'b1;
            end
            else
            begin
                hold_count_next = count_inc;
            end
            if (hold_count_next >= debounce_count_reg)
            begin
                changing_next = 1'b0;
                if (online_flag_reg && !level_seen_next)
                begin
                    online_flag_next = 1'b0;
                    event_next       = ppd_pkg::EV_OFF;
                end
                else if (!online_flag_reg && level_seen_next)
                begin
                    online_flag_next = 1'b1;
                    event_next       = ppd_pkg::EV_ON;
                end
            end
            if (!changing_next)
            begin
                awake_next     = 1'b0;
                fast_scan_next = 1'b0;
            end
            settling_next = changing_next;
        end
    end

    // Detector state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_seen_reg  <= 1'b0;
            hold_count_reg  <= '0;
            changing_reg    <= 1'b0;
            online_flag_reg <= 1'b0;
            awake_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                level_seen_reg  <= level_seen_next;
                hold_count_reg  <= hold_count_next;
                changing_reg    <= changing_next;
                online_flag_reg <= online_flag_next;
                awake_reg       <= awake_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            event_reg     <= event_next;
            settling_reg  <= settling_next;
            fast_scan_reg <= fast_scan_next;
            present_reg   <= online_flag_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the plug presence debouncer: random and directed sample words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // ADC width used for this build, and the config data width (widest register)
    localparam int          ADC_W       = 10;
    localparam int          CFG_DATA_W  = 10;
    localparam logic [9:0]  ADC_MAX     = 10'd1023;
    // An index past the register list; writes to it must change nothing
    localparam logic [2:0]  REG_UNUSED  = 3'd7;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          REPORT_MAX  = 10;

    // One sample word as it goes into the block
    typedef struct packed {
        logic              pin;
        logic [ADC_W-1:0]  adc;
        logic              ok;
    } sample_t;

    // One result word as it should come out
    typedef struct packed {
        ppd_pkg::event_t  ev;
        logic             settle;
        logic             fast;
        logic             pres;
    } tick_result_t;

    // ---------------------------------------------------------------
    // Block ports; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             cfg_we     = 1'b0;
    logic [ppd_pkg::CFG_INDEX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0]            cfg_data   = '0;
    logic                             in_valid   = 1'b0;
    logic                             in_ready;
    logic                             pin_level  = 1'b1;
    logic [ADC_W-1:0]                 adc_value  = '0;
    logic                             sample_ok  = 1'b1;
    logic                             out_valid;
    logic                             out_ready  = 1'b0;
    logic [1:0]                       event_res;
    logic                             settling;
    logic                             fast_scan;
    logic                             present;

    plug_presence_debouncer_unit #(
        .ADC_BITS (ADC_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pin_level (pin_level),
        .adc_value (adc_value),
        .sample_ok (sample_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .settling  (settling),
        .fast_scan (fast_scan),
        .present   (present)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: register copy and detector state, reset values
    // ---------------------------------------------------------------
    logic                        m_use_adc  = 1'b0;
    logic [ADC_W-1:0]            m_thr      = ADC_W'(ppd_pkg::THRESHOLD_RESET);
    logic                        m_pull_up  = 1'b1;
    logic [ppd_pkg::COUNT_W-1:0] m_debounce = ppd_pkg::DEBOUNCE_RESET;
    logic                        m_mux      = 1'b0;

    logic                        m_level    = 1'b0;
    logic [ppd_pkg::COUNT_W-1:0] m_count    = '0;
    logic                        m_changing = 1'b0;
    logic                        m_online   = 1'b0;
    logic                        m_awake    = 1'b0;

    // Stores: words waiting to be driven, results waiting to arrive
    sample_t       sample_backlog[$];
    tick_result_t  expected_results[$];

    int unsigned cycles      = 0;
    int unsigned faults      = 0;
    int unsigned n_taken     = 0;
    int unsigned n_results   = 0;
    int unsigned n_on        = 0;
    int unsigned n_off       = 0;
    int unsigned n_settings  = 0;

    // Advances the detector by one tick and gives the result word it must produce
    function automatic tick_result_t debounce_tick(sample_t s);
        tick_result_t r;
        logic         sensed;
        r.ev   = ppd_pkg::EV_NONE;
        r.fast = 1'b1;
        if (m_mux) begin
            // one-shot sampling: no polarity inversion, failed ADC run keeps level
            if (!m_use_adc)
                sensed = ~s.pin;
            else if (s.ok)
                sensed = (s.adc <= m_thr);
            else
                sensed = m_level;
            if (sensed == m_level)
                m_count = '0;
            else
            begin
                if (m_count != ppd_pkg::COUNT_MAX)
                    m_count = m_count + 8'd1;
                if (m_count >= m_debounce)
                begin
                    m_count  = '0;
                    m_level  = sensed;
                    m_online = sensed;
                    r.ev     = sensed ? ppd_pkg::EV_ON : ppd_pkg::EV_OFF;
                end
            end
            r.settle = (m_count != '0);
        end
        else if (!m_awake)
        begin
            // wake tick only arms sampling
            m_awake  = 1'b1;
            r.settle = m_changing;
        end
        else
        begin
            sensed = m_use_adc ? (s.adc <= m_thr) : ~s.pin;
            if (!m_pull_up)
                sensed = ~sensed;
            if (sensed != m_level)
            begin
                m_level    = sensed;
                m_count    = '0;
                m_changing = 1'b1;
            end
            else if (m_count != ppd_pkg::COUNT_MAX)
                m_count = m_count + 8'd1;
            if (m_count >= m_debounce)
            begin
                m_changing = 1'b0;
                if (m_online && !m_level)
                begin
                    m_online = 1'b0;
                    r.ev     = ppd_pkg::EV_OFF;
                end
                else if (!m_online && m_level)
                begin
                    m_online = 1'b1;
                    r.ev     = ppd_pkg::EV_ON;
                end
            end
            if (!m_changing)
            begin
                m_awake = 1'b0;
                r.fast  = 1'b0;
            end
            r.settle = m_changing;
        end
        r.pres = m_online;
        return r;
    endfunction

    // Builds a word whose sensed level (before any inversion) is raw, but for raw 0 under a
    // threshold at ADC_MAX; the fields the current setting ignores are random
    function automatic sample_t make_sample(logic raw);
        sample_t s;
        s.pin = 1'($urandom_range(0, 1));
        s.adc = ADC_W'($urandom_range(0, ADC_MAX));
        s.ok  = 1'($urandom_range(0, 1));
        if (!m_use_adc)
            s.pin = ~raw;
        else
        begin
            // now and then sit right on the threshold edge
            if (raw)
                s.adc = ($urandom_range(0, 7) == 0) ? m_thr
                                                     : ADC_W'($urandom_range(0, m_thr));
            else if (m_thr != ADC_MAX)
                s.adc = ($urandom_range(0, 7) == 0) ? m_thr + 10'd1
                                                     : ADC_W'($urandom_range(m_thr + 1,
                                                                             ADC_MAX));
            // roughly one ADC run in ten fails in multiplexed mode
            if (m_mux)
                s.ok = ($urandom_range(0, 9) != 0);
        end
        return s;
    endfunction

    task automatic report_fault(string msg);
        faults++;
        if (faults <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endtask

    // Register write, one per edge; the predictor copy follows at once
    // since writes only happen while nothing is in flight
    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ppd_pkg::REG_USE_ADC:        m_use_adc  = val[0];
            ppd_pkg::REG_ADC_THRESHOLD:  m_thr      = val[ADC_W-1:0];
            ppd_pkg::REG_PULL_UP_FITTED: m_pull_up  = val[0];
            ppd_pkg::REG_DEBOUNCE_COUNT: m_debounce = val[ppd_pkg::COUNT_W-1:0];
            ppd_pkg::REG_SAMPLING_MODE:  m_mux      = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic use_adc, int thr, logic pull_up, int deb, logic mux);
        write_reg(ppd_pkg::REG_USE_ADC,        CFG_DATA_W'(use_adc));
        write_reg(ppd_pkg::REG_ADC_THRESHOLD,  CFG_DATA_W'(thr));
        write_reg(ppd_pkg::REG_PULL_UP_FITTED, CFG_DATA_W'(pull_up));
        write_reg(ppd_pkg::REG_DEBOUNCE_COUNT, CFG_DATA_W'(deb));
        write_reg(ppd_pkg::REG_SAMPLING_MODE,  CFG_DATA_W'(mux));
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Sender holds off until every word is through and every result is in,
    // then lets the result register settle
    task automatic wait_quiet();
        while (sample_backlog.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Runs of a steady level, mostly long enough to pass the debounce, some
    // short, with the odd one-word glitch. The first run always heads for
    // the opposite of the current accepted level so that a setting
    // normally produces at least one event.
    task automatic queue_phase(int n);
        int   left;
        int   len;
        logic raw;
        logic glitch;
        bit   first;
        left  = n;
        first = 1'b1;
        while (left > 0)
        begin
            if (first)
                raw = m_mux ? ~m_level : (m_online ^ m_pull_up);
            else
                raw = $urandom_range(0, 1);
            if (first || $urandom_range(0, 3) != 0)
                len = int'(m_debounce) + 2 + $urandom_range(0, 3);
            else
                len = $urandom_range(1, int'(m_debounce) + 1);
            first = 1'b0;
            for (int i = 0; i < len && left > 0; i++)
            begin
                // no glitches on long holds, they would never get through
                glitch = (m_debounce < 16) && ($urandom_range(0, 15) == 0);
                sample_backlog.push_back(make_sample(raw ^ glitch));
                left--;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: presents backlog words, random gap after each word, with
    // calm stretches where the gap is forced to zero
    // ---------------------------------------------------------------
    int unsigned tx_gap  = 0;
    logic        tx_calm = 1'b0;
    sample_t     next_word;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (sample_backlog.size() != 0)
            begin
                next_word = sample_backlog.pop_front();
                pin_level <= next_word.pin;
                adc_value <= next_word.adc;
                sample_ok <= next_word.ok;
                in_valid  <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    tx_calm <= ~tx_calm;
                tx_gap <= tx_calm ? 0 : $urandom_range(0, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Input monitor: each accepted word steps the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(debounce_tick('{pin: pin_level, adc: adc_value,
                                                       ok: sample_ok}));
            n_taken++;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: checks each result word, then drops out_ready for a random
    // stall (or not at all during a calm stretch)
    // ---------------------------------------------------------------
    int unsigned  rx_stall = 0;
    int unsigned  rx_draw;
    logic         rx_calm  = 1'b0;
    tick_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            n_results++;
            if (event_res == ppd_pkg::EV_ON)
                n_on++;
            if (event_res == ppd_pkg::EV_OFF)
                n_off++;
            if (expected_results.size() == 0)
                report_fault($sformatf({"result word with none outstanding:",
                                        " ev %0d set %0b fast %0b pres %0b"},
                                       event_res, settling, fast_scan, present));
            else
            begin
                want = expected_results.pop_front();
                if (event_res !== want.ev || settling !== want.settle ||
                    fast_scan !== want.fast || present !== want.pres)
                    report_fault($sformatf({"result %0d mismatch: ev %0d/%0d",
                                            " settling %0b/%0b",
                                            " fast_scan %0b/%0b present %0b/%0b (exp/act)"},
                                           n_results, want.ev, event_res, want.settle, settling,
                                           want.fast, fast_scan, want.pres, present));
            end
            if ($urandom_range(0, 15) == 0)
                rx_calm <= ~rx_calm;
            rx_draw = rx_calm ? 0 : $urandom_range(0, 7);
            rx_stall  <= rx_draw;
            out_ready <= (rx_draw == 0);
        end
        else if (rx_stall > 1)
            rx_stall <= rx_stall - 1;
        else
        begin
            rx_stall  <= 0;
            out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings (pin sensing, pull-up fitted, count 3,
        // continuous). Plug in long enough to come online: wake, change,
        // three holds, then the next wake.
        repeat (6) sample_backlog.push_back('{pin: 1'b0, adc: ADC_MAX, ok: 1'b0});
        // one-word glitch then back to present: change and recover
        sample_backlog.push_back('{pin: 1'b1, adc: 10'd0, ok: 1'b1});
        repeat (5) sample_backlog.push_back('{pin: 1'b0, adc: ADC_MAX, ok: 1'b1});
        // pull the plug: offline event
        repeat (6) sample_backlog.push_back('{pin: 1'b1, adc: 10'd0, ok: 1'b1});
        // ADC values either side of the default threshold, ignored here
        sample_backlog.push_back('{pin: 1'b0, adc: 10'd512, ok: 1'b0});
        sample_backlog.push_back('{pin: 1'b1, adc: 10'd513, ok: 1'b1});
        wait_quiet();

        // Continuous, pin, pull-up absent (inverted), count 1
        set_config(1'b0, 512, 1'b0, 1, 1'b0);
        queue_phase(40);
        wait_quiet();

        // Continuous ADC at the default threshold; stray index must be ignored
        write_reg(REG_UNUSED, '1);
        set_config(1'b1, 512, 1'b1, 3, 1'b0);
        queue_phase(50);
        wait_quiet();

        // Continuous ADC, threshold at its floor, inverted
        set_config(1'b1, 0, 1'b0, 2, 1'b0);
        queue_phase(30);
        wait_quiet();

        // Multiplexed, pin sensing
        set_config(1'b0, 512, 1'b1, 3, 1'b1);
        queue_phase(40);
        wait_quiet();

        // Multiplexed ADC with failed runs; pull-up setting has no effect here
        set_config(1'b1, 700, 1'b0, 2, 1'b1);
        queue_phase(50);
        wait_quiet();

        // Multiplexed ADC, threshold at its ceiling, zero count
        set_config(1'b1, 1023, 1'b1, 0, 1'b1);
        queue_phase(20);
        wait_quiet();

        // Continuous pin, zero count accepts at once
        set_config(1'b0, 100, 1'b1, 0, 1'b0);
        queue_phase(20);
        wait_quiet();

        // Multiplexed pin, longest count
        set_config(1'b0, 512, 1'b1, 255, 1'b1);
        queue_phase(275);
        wait_quiet();

        if (expected_results.size() != 0)
            report_fault($sformatf("%0d result words never arrived", expected_results.size()));

        $display("Covered %0d sample words over %0d register settings: pin and ADC sensing,",
                 n_taken, n_settings + 1);
        $display("both sampling modes, counts 0..255; %0d results with %0d online, %0d offline.",
                 n_results, n_on, n_off);
        if (faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ppd_pkg.sv
hdl/plug_presence_debouncer_unit.sv
tb/testbench.sv
